### hdl/ibib_pkg.sv
// Shared widths, limits and codes for the interpolation bucket index builder.
`default_nettype none

package ibib_pkg;

	localparam int KEY_W = 64;
	localparam int BKT_W = 17;
	localparam int IDX_W = 21;
	localparam int CFG_IDX_W = 2;

	localparam logic [BKT_W-1:0] MAX_BUCKETS  = BKT_W'(65536);
	localparam logic [IDX_W-1:0] MAX_ELEMENTS = IDX_W'(1048576);

	// Result kinds
	localparam logic [1:0] KIND_FILL = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_SUM  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_MIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_MAX    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_REQ = 2'd2;

endpackage

`default_nettype wire

### hdl/ibib_if.sv
// Key input and command output channel interfaces.
`default_nettype none

interface ibib_key_if
	import ibib_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key;
	logic             last_item;

	modport source (output valid, key, last_item, input ready);
	modport sink   (input valid, key, last_item, output ready);
endinterface

interface ibib_cmd_if
	import ibib_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [BKT_W-1:0] settled_bucket;
	logic             settled_flag;
	logic [BKT_W-1:0] fill_low;
	logic [BKT_W-1:0] fill_high;
	logic [IDX_W-1:0] start_index;
	logic [BKT_W-1:0] bucket_total;
	logic             last;

	modport source (output valid, kind, settled_bucket, settled_flag, fill_low, fill_high,
		start_index, bucket_total, last, input ready);
	modport sink   (input valid, kind, settled_bucket, settled_flag, fill_low, fill_high,
		start_index, bucket_total, last, output ready);
endinterface

`default_nettype wire

### hdl/ibib_mulh.sv
// High half of a 64x64 product from four 32x32 partial products, one per cycle.
`default_nettype none

module ibib_mulh
	import ibib_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [KEY_W-1:0] a,
	input  wire logic [KEY_W-1:0] b,
	output logic                  done,
	output logic      [KEY_W-1:0] high
);

	localparam int HALF_W = KEY_W / 2;

	logic [KEY_W-1:0]   a_q, b_q;
	logic [2*KEY_W-1:0] acc_q;
	logic [KEY_W-1:0]   prod_s1;
	logic [1:0]         sh_s1;
	logic               pv_s1;
	logic [2:0]         step_q;
	logic               busy_q;
	logic [HALF_W-1:0]  a_sel, b_sel;
	logic [2*KEY_W-1:0] addend;

	// step 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi
	assign a_sel = step_q[1] ? a_q[KEY_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign b_sel = step_q[0] ? b_q[KEY_W-1:HALF_W] : b_q[HALF_W-1:0];

	// align the registered partial product
	always_comb begin
		case (sh_s1)
			2'd0:    addend = {{KEY_W{1'b0}}, prod_s1};
			2'd3:    addend = {prod_s1, {KEY_W{1'b0}}};
			default: addend = {{HALF_W{1'b0}}, prod_s1, {HALF_W{1'b0}}};
		endcase
	end

	assign done = busy_q && (step_q == 3'd4) && !pv_s1;
	assign high = acc_q[2*KEY_W-1:KEY_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			pv_s1  <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			pv_s1  <= 1'b0;
		end else if (busy_q) begin
			pv_s1 <= (step_q != 3'd4);
			if (step_q != 3'd4)
				step_q <= step_q + 3'd1;
			if (done)
				busy_q <= 1'b0;
		end
	end

	// operands, partial product and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			prod_s1 <= a_sel * b_sel;
			sh_s1   <= step_q[1:0];
			if (pv_s1)
				acc_q <= acc_q + addend;
		end
	end

endmodule

`default_nettype wire

### hdl/ibib_div.sv
// Restoring 64/64 unsigned divider, one quotient bit per cycle.
`default_nettype none

module ibib_div
	import ibib_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [KEY_W-1:0] num,
	input  wire logic [KEY_W-1:0] den,
	output logic                  done,
	output logic      [KEY_W-1:0] quo
);

	localparam int CNT_W = $clog2(KEY_W + 1);

	logic [KEY_W-1:0] rem_q, quo_q, den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [KEY_W:0]   trial, diff;
	logic             ge;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[KEY_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = !diff[KEY_W];
	assign done  = busy_q && (cnt_q == CNT_W'(KEY_W));
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (done)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q && !done) begin
			rem_q <= ge ? diff[KEY_W-1:0] : trial[KEY_W-1:0];
			quo_q <= {quo_q[KEY_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

### hdl/interpolation_bucket_index_builder_top.sv
// Interpolation bucket index builder: configuration, sequencer and command output.
//
// Takes the keys of a sorted array one transaction at a time and issues the write
// commands that build a bucket start-index table. The first key of an array latches
// key_min, key_max and bucket_request and runs the setup on a shared restoring divider
// (two divisions, one for the bucket size and one for the scale multiplier) followed by
// two high products (top bucket, then the key), and then issues its commands; with a
// bucket size of one the second division is skipped. Every later key is accepted, goes
// through the high product on the shared 32x32 multiplier (four partial products and
// the accumulation), is decided on and then issues its commands. In single-bucket mode
// a key goes straight from acceptance to the decide step, with the summary issued on
// the last key. The key port is ready only between keys; a command waiting in the
// output register does not block the next key from being taken, but a further command
// waits in its issue state until the register is free, so output stalls delay the
// sequencer. Configuration writes take effect on the next array.
`default_nettype none

module interpolation_bucket_index_builder_top
	import ibib_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	ibib_key_if.sink                  keys,
	ibib_cmd_if.source                cmds,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [KEY_W-1:0]     cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_SIZE,
		ST_DIV_MULT,
		ST_MUL_TOP,
		ST_MUL_KEY,
		ST_DECIDE,
		ST_PUT_FILL,
		ST_PUT_END,
		ST_PUT_SUM
	} state_t;

	state_t state_q;

	// configuration registers
	logic [KEY_W-1:0] key_min_q, key_max_q;
	logic [BKT_W-1:0] bkt_req_q;

	// per-array setup and per-key state
	logic [KEY_W-1:0] base_q, delta_q, size_q, mult_q;
	logic [BKT_W-1:0] n_q, top_q, cur_q, idx_q;
	logic             single_q, zero_q;
	logic [KEY_W-1:0] key_q, bsk_q, prev_q;
	logic             fin_q;
	logic [IDX_W-1:0] elem_cnt_q;

	// output register
	logic             out_valid_q;
	logic [1:0]       o_kind_q;
	logic [BKT_W-1:0] o_sb_q, o_lo_q, o_hi_q, o_tot_q;
	logic             o_sf_q, o_last_q;
	logic [IDX_W-1:0] o_si_q;

	// shared units
	logic             div_start_q, div_done;
	logic [KEY_W-1:0] div_num, div_den, div_quo;
	logic             mul_start_q, mul_done;
	logic [KEY_W-1:0] mul_b, mul_high;

	logic [KEY_W-1:0] delta_c;
	logic [BKT_W-1:0] req_c, n_c, top_c, idx_c;
	logic [IDX_W-1:0] count_c;
	logic             out_free, first_c, fill_flag;
	logic             single_c, div_start_c, mul_start_c, out_load;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_min_q <= '0;
			key_max_q <= '0;
			bkt_req_q <= BKT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_MIN:    key_min_q <= cfg_wdata;
				CFG_KEY_MAX:    key_max_q <= cfg_wdata;
				CFG_BUCKET_REQ: bkt_req_q <= cfg_wdata[BKT_W-1:0];
				default:        ;
			endcase
		end
	end

	// setup terms taken on the first key
	assign delta_c  = key_max_q - key_min_q;
	assign req_c    = (bkt_req_q > MAX_BUCKETS) ? MAX_BUCKETS : bkt_req_q;
	assign n_c      = ({{(KEY_W-BKT_W){1'b0}}, req_c} > delta_c) ? delta_c[BKT_W-1:0] : req_c;
	assign single_c = (bkt_req_q <= BKT_W'(1)) || (delta_c <= KEY_W'(1));

	// operand selection for the shared units
	assign div_num = (state_q == ST_DIV_SIZE) ? delta_q - KEY_W'(1) : {KEY_W{1'b1}};
	assign div_den = (state_q == ST_DIV_SIZE) ? {{(KEY_W-BKT_W){1'b0}}, n_q} : size_q;
	assign mul_b   = (state_q == ST_MUL_TOP) ? delta_q : key_q - base_q;

	// clamps on the product
	assign top_c = (mul_high > {{(KEY_W-BKT_W){1'b0}}, MAX_BUCKETS}) ? MAX_BUCKETS
		: mul_high[BKT_W-1:0];
	assign idx_c = (mul_high > {{(KEY_W-BKT_W){1'b0}}, top_q}) ? top_q : mul_high[BKT_W-1:0];

	assign count_c   = (elem_cnt_q < MAX_ELEMENTS) ? elem_cnt_q + IDX_W'(1) : MAX_ELEMENTS;
	assign first_c   = (elem_cnt_q == '0);
	assign fill_flag = first_c || (bsk_q == prev_q);
	assign out_free  = !out_valid_q || cmds.ready;

	// start pulses for the shared units and output register load
	assign div_start_c = ((state_q == ST_IDLE) && keys.valid && first_c && !single_c)
		|| ((state_q == ST_DIV_SIZE) && div_done && (div_quo != '0));
	assign mul_start_c = ((state_q == ST_IDLE) && keys.valid && !first_c && !single_q)
		|| ((state_q == ST_DIV_SIZE) && div_done && (div_quo == '0))
		|| ((state_q == ST_DIV_MULT) && div_done)
		|| ((state_q == ST_MUL_TOP) && mul_done);
	assign out_load = ((state_q == ST_PUT_FILL) || (state_q == ST_PUT_END)
		|| (state_q == ST_PUT_SUM)) && out_free;

	ibib_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	ibib_mulh u_mulh (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mult_q),
		.b      (mul_b),
		.done   (mul_done),
		.high   (mul_high)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			single_q    <= 1'b0;
			zero_q      <= 1'b0;
			elem_cnt_q  <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= div_start_c;
			mul_start_q <= mul_start_c;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (cmds.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (keys.valid) begin
						key_q <= keys.key;
						fin_q <= keys.last_item;
						if (first_c) begin
							base_q   <= key_min_q;
							delta_q  <= delta_c;
							zero_q   <= (delta_c == '0);
							n_q      <= n_c;
							cur_q    <= '0;
							bsk_q    <= keys.key;
							if (single_c) begin
								single_q <= 1'b1;
								state_q  <= ST_DECIDE;
							end else begin
								single_q <= 1'b0;
								state_q  <= ST_DIV_SIZE;
							end
						end else if (single_q) begin
							state_q <= ST_DECIDE;
						end else begin
							state_q <= ST_MUL_KEY;
						end
					end
				end
				ST_DIV_SIZE: begin
					if (div_done) begin
						if (div_quo == '0) begin
							mult_q  <= {KEY_W{1'b1}};
							state_q <= ST_MUL_TOP;
						end else begin
							size_q  <= div_quo + KEY_W'(1);
							state_q <= ST_DIV_MULT;
						end
					end
				end
				ST_DIV_MULT: begin
					if (div_done) begin
						mult_q  <= div_quo + KEY_W'(1);
						state_q <= ST_MUL_TOP;
					end
				end
				ST_MUL_TOP: begin
					if (mul_done) begin
						top_q   <= top_c;
						state_q <= ST_MUL_KEY;
					end
				end
				ST_MUL_KEY: begin
					if (mul_done) begin
						idx_q   <= idx_c;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (single_q) begin
						if (fin_q) begin
							state_q <= ST_PUT_SUM;
						end else begin
							prev_q     <= key_q;
							elem_cnt_q <= count_c;
							state_q    <= ST_IDLE;
						end
					end else if (idx_q > cur_q) begin
						state_q <= ST_PUT_FILL;
					end else if (fin_q) begin
						state_q <= ST_PUT_END;
					end else begin
						prev_q     <= key_q;
						elem_cnt_q <= count_c;
						state_q    <= ST_IDLE;
					end
				end
				ST_PUT_FILL: begin
					if (out_free) begin
						o_kind_q    <= KIND_FILL;
						o_sb_q      <= cur_q;
						o_sf_q      <= fill_flag;
						o_lo_q      <= cur_q + BKT_W'(1);
						o_hi_q      <= idx_q;
						o_si_q      <= elem_cnt_q;
						o_tot_q     <= '0;
						o_last_q    <= !fin_q;
						cur_q       <= idx_q;
						bsk_q       <= key_q;
						if (fin_q) begin
							state_q <= ST_PUT_END;
						end else begin
							prev_q     <= key_q;
							elem_cnt_q <= count_c;
							state_q    <= ST_IDLE;
						end
					end
				end
				ST_PUT_END: begin
					if (out_free) begin
						o_kind_q    <= KIND_END;
						o_sb_q      <= cur_q;
						o_sf_q      <= (bsk_q == key_q);
						o_lo_q      <= top_q + BKT_W'(1);
						o_hi_q      <= '0;
						o_si_q      <= count_c;
						o_tot_q     <= top_q + BKT_W'(1);
						o_last_q    <= 1'b1;
						prev_q      <= key_q;
						elem_cnt_q  <= '0;
						cur_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				ST_PUT_SUM: begin
					if (out_free) begin
						o_kind_q    <= KIND_SUM;
						o_sb_q      <= '0;
						o_sf_q      <= zero_q;
						o_lo_q      <= '0;
						o_hi_q      <= '0;
						o_si_q      <= count_c;
						o_tot_q     <= BKT_W'(1);
						o_last_q    <= 1'b1;
						prev_q      <= key_q;
						elem_cnt_q  <= '0;
						cur_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign keys.ready = (state_q == ST_IDLE);

	assign cmds.valid          = out_valid_q;
	assign cmds.kind           = o_kind_q;
	assign cmds.settled_bucket = o_sb_q;
	assign cmds.settled_flag   = o_sf_q;
	assign cmds.fill_low       = o_lo_q;
	assign cmds.fill_high      = o_hi_q;
	assign cmds.start_index    = o_si_q;
	assign cmds.bucket_total   = o_tot_q;
	assign cmds.last           = o_last_q;

endmodule

`default_nettype wire

### bench/interpolation_bucket_index_builder_top_tb.sv
// Self-checking testbench for the interpolation bucket index builder.

module interpolation_bucket_index_builder_top_tb
	import ibib_pkg::*;
();

	localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int unsigned CYCLE_LIMIT = 400_000;
	localparam int unsigned RAND_ITEMS  = 500;
	localparam int unsigned KEY_LATENCY = 16;

	typedef struct packed {
		logic [1:0]       kind;
		logic [BKT_W-1:0] settled_bucket;
		logic             settled_flag;
		logic [BKT_W-1:0] fill_low;
		logic [BKT_W-1:0] fill_high;
		logic [IDX_W-1:0] start_index;
		logic [BKT_W-1:0] bucket_total;
		logic             last;
	} table_cmd_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KEY_W-1:0]     cfg_wdata;

	ibib_key_if key_ch ();
	ibib_cmd_if cmd_ch ();

	interpolation_bucket_index_builder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.keys      (key_ch),
		.cmds      (cmd_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Register copies as the block holds them
	logic [KEY_W-1:0] reg_key_min    = '0;
	logic [KEY_W-1:0] reg_key_max    = '0;
	logic [BKT_W-1:0] reg_bucket_req = BKT_W'(1);

	// Table builder state, mirrored
	logic [63:0]      scale_mult     = '0;
	logic             single_mode    = 1'b0;
	logic [BKT_W-1:0] cur_bucket     = '0;
	logic [63:0]      run_start_key  = '0;
	logic [63:0]      prev_key       = '0;
	logic [IDX_W-1:0] elem_count     = '0;
	logic [63:0]      base_key       = '0;
	logic [BKT_W-1:0] top_bucket     = '0;
	logic             zero_delta     = 1'b0;

	table_cmd_t  table_cmds_due[$];
	table_cmd_t  due_cmd;
	int unsigned mismatches   = 0;
	int unsigned cycle_count  = 0;
	int unsigned tx_gap_max   = 0;
	int unsigned rx_stall_max = 0;
	int unsigned sink_stall;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Uniform-ish value in [0, bound]
	function automatic logic [63:0] rand_upto(input logic [63:0] bound);
		if (bound == ALL_ONES)
			return rand64();
		return rand64() % (bound + 64'd1);
	endfunction

	function automatic logic [63:0] high_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[127:64];
	endfunction

	// Works out the commands one accepted key causes and queues them
	task automatic predict_table_writes(input logic [63:0] key, input logic fin);
		logic [63:0]      delta;
		logic [63:0]      nb;
		logic [63:0]      bkt_size;
		logic [63:0]      bkt;
		logic [IDX_W-1:0] count;
		logic             flag;
		// first key of an array latches the setup
		if (elem_count == '0) begin
			delta       = reg_key_max - reg_key_min;
			base_key    = reg_key_min;
			zero_delta  = (delta == 64'd0);
			scale_mult  = '0;
			top_bucket  = '0;
			single_mode = (reg_bucket_req <= BKT_W'(1)) || (delta <= 64'd1);
			if (!single_mode) begin
				nb = 64'(reg_bucket_req);
				if (nb > 64'(MAX_BUCKETS))
					nb = 64'(MAX_BUCKETS);
				if (nb > delta)
					nb = delta;
				bkt_size   = 64'd1 + (delta - 64'd1) / nb;
				scale_mult = (bkt_size == 64'd1) ? ALL_ONES : ALL_ONES / bkt_size + 64'd1;
				bkt        = high_product(scale_mult, delta);
				if (bkt > 64'(MAX_BUCKETS))
					bkt = 64'(MAX_BUCKETS);
				top_bucket = bkt[BKT_W-1:0];
			end
			cur_bucket    = '0;
			run_start_key = key;
		end
		count = (elem_count < MAX_ELEMENTS) ? elem_count + IDX_W'(1) : MAX_ELEMENTS;

		if (single_mode) begin
			if (fin)
				table_cmds_due.push_back('{kind: KIND_SUM, settled_bucket: '0,
					settled_flag: zero_delta, fill_low: '0, fill_high: '0,
					start_index: count, bucket_total: BKT_W'(1), last: 1'b1});
		end else begin
			bkt = high_product(scale_mult, key - base_key);
			if (bkt > 64'(top_bucket))
				bkt = 64'(top_bucket);
			// key moved on to a later bucket: settle the pending one and fill
			if (bkt > 64'(cur_bucket)) begin
				flag = (elem_count == '0) ? 1'b1 : (run_start_key == prev_key);
				table_cmds_due.push_back('{kind: KIND_FILL, settled_bucket: cur_bucket,
					settled_flag: flag, fill_low: cur_bucket + BKT_W'(1),
					fill_high: bkt[BKT_W-1:0], start_index: elem_count,
					bucket_total: '0, last: !fin});
				cur_bucket    = bkt[BKT_W-1:0];
				run_start_key = key;
			end
			if (fin)
				table_cmds_due.push_back('{kind: KIND_END, settled_bucket: cur_bucket,
					settled_flag: (run_start_key == key),
					fill_low: top_bucket + BKT_W'(1), fill_high: '0, start_index: count,
					bucket_total: top_bucket + BKT_W'(1), last: 1'b1});
		end

		prev_key   = key;
		elem_count = count;
		if (fin) begin
			elem_count = '0;
			cur_bucket = '0;
		end
	endtask

	// Sends one key and predicts its commands once the transaction completes
	task automatic send_key(input logic [63:0] key, input logic fin);
		int unsigned gap;
		gap = $urandom_range(tx_gap_max, 0);
		@(negedge clk);
		if (gap != 0) begin
			key_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		key_ch.valid     <= 1'b1;
		key_ch.key       <= key;
		key_ch.last_item <= fin;
		do @(posedge clk); while (!key_ch.ready);
		predict_table_writes(key, fin);
	endtask

	// Stops sending and waits until every predicted command has come out
	task automatic wait_for_table();
		@(negedge clk);
		key_ch.valid <= 1'b0;
		while (table_cmds_due.size() != 0)
			@(posedge clk);
	endtask

	// Writes all three registers once the block is idle
	task automatic set_config(input logic [63:0] kmin, input logic [63:0] kmax,
		input logic [63:0] req_data);
		wait_for_table();
		repeat (KEY_LATENCY) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_KEY_MIN;
		cfg_wdata <= kmin;
		@(negedge clk);
		cfg_index <= CFG_KEY_MAX;
		cfg_wdata <= kmax;
		@(negedge clk);
		cfg_index <= CFG_BUCKET_REQ;
		cfg_wdata <= req_data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		reg_key_min    = kmin;
		reg_key_max    = kmax;
		reg_bucket_req = req_data[BKT_W-1:0];
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Command sink with random stalls
	initial begin
		cmd_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			sink_stall = $urandom_range(rx_stall_max, 0);
			repeat (sink_stall) begin
				@(negedge clk);
				cmd_ch.ready <= 1'b0;
			end
			@(negedge clk);
			cmd_ch.ready <= 1'b1;
			do @(posedge clk); while (!cmd_ch.valid);
		end
	end

	// Compare each command transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			if (table_cmds_due.size() == 0) begin
				$error("command with no prediction waiting: kind %0d", cmd_ch.kind);
				mismatches++;
			end else begin
				due_cmd = table_cmds_due.pop_front();
				check_field("kind", 64'(due_cmd.kind), 64'(cmd_ch.kind));
				check_field("settled_bucket", 64'(due_cmd.settled_bucket),
					64'(cmd_ch.settled_bucket));
				check_field("settled_flag", 64'(due_cmd.settled_flag), 64'(cmd_ch.settled_flag));
				check_field("fill_low", 64'(due_cmd.fill_low), 64'(cmd_ch.fill_low));
				check_field("fill_high", 64'(due_cmd.fill_high), 64'(cmd_ch.fill_high));
				check_field("start_index", 64'(due_cmd.start_index), 64'(cmd_ch.start_index));
				check_field("bucket_total", 64'(due_cmd.bucket_total), 64'(cmd_ch.bucket_total));
				check_field("last", 64'(due_cmd.last), 64'(cmd_ch.last));
			end
		end
	end

	// One bucket requested, zero span and unit span all give only the summary
	task automatic test_single_bucket();
		send_key(64'd0, 1'b1);
		set_config(64'd5, 64'd6, 64'd0);
		send_key(64'd5, 1'b0);
		send_key(64'd6, 1'b1);
		set_config(64'd7, 64'd7, 64'd100);
		send_key(64'd7, 1'b0);
		send_key(64'd7, 1'b1);
	endtask

	// Full key range, at and above the bucket ceiling
	task automatic test_full_range();
		set_config(64'd0, ALL_ONES, 64'(MAX_BUCKETS));
		send_key(64'd0, 1'b0);
		send_key(64'd1, 1'b0);
		send_key(64'h8000_0000_0000_0000, 1'b0);
		send_key(ALL_ONES, 1'b1);
		set_config(64'd0, ALL_ONES, 64'h1FFFF);
		send_key(64'd5, 1'b0);
		send_key(ALL_ONES, 1'b1);
	endtask

	// Empty first bucket, repeats, descending and out-of-range keys,
	// an unreached top bucket and a span that wraps round zero
	task automatic test_bucket_edges();
		set_config(64'd1000, 64'd2000, 64'd10);
		send_key(64'd1250, 1'b0);
		send_key(64'd1250, 1'b0);
		send_key(64'd1100, 1'b0);
		send_key(64'd1300, 1'b0);
		// hold off until the table has caught up, mid-array
		wait_for_table();
		send_key(64'd5000, 1'b0);
		send_key(64'd3, 1'b1);
		send_key(64'd1000, 1'b0);
		send_key(64'd1050, 1'b0);
		send_key(64'd1500, 1'b1);
		set_config(ALL_ONES - 64'd9, 64'd20, 64'd4);
		send_key(ALL_ONES - 64'd9, 1'b0);
		send_key(64'd0, 1'b0);
		send_key(64'd20, 1'b1);
	endtask

	// Random arrays, mostly sorted, under random configuration and pacing
	task automatic test_random_arrays();
		int unsigned sent;
		int unsigned len;
		int unsigned j;
		bit          noisy;
		logic [63:0] kmin;
		logic [63:0] span;
		logic [63:0] req;
		logic [63:0] off;
		logic [63:0] step_max;
		logic [63:0] room;
		logic [63:0] key;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			if (sent == 0 || $urandom_range(9, 0) < 7) begin
				case ($urandom_range(3, 0))
					0: kmin = 64'd0;
					1: kmin = ALL_ONES - rand_upto(64'd1000);
					default: kmin = rand64();
				endcase
				case ($urandom_range(5, 0))
					0: span = 64'($urandom_range(3, 0));
					1: span = 64'($urandom_range(2000, 2));
					2: span = {32'd0, $urandom};
					3: span = rand64();
					4: span = ALL_ONES;
					default: span = 64'($urandom_range(200000, 60000));
				endcase
				case ($urandom_range(5, 0))
					0: req = 64'($urandom_range(1, 0));
					1: req = 64'($urandom_range(64, 2));
					2: req = 64'($urandom_range(65536, 2));
					3: req = 64'(MAX_BUCKETS);
					4: req = 64'($urandom_range(131071, 65537));
					default: req = 64'($urandom_range(4096, 200));
				endcase
				// stray upper bits on the bucket count write
				if ($urandom_range(9, 0) == 0)
					req = (rand64() << BKT_W) | {{(64-BKT_W){1'b0}}, req[BKT_W-1:0]};
				set_config(kmin, kmin + span, req);
			end
			case ($urandom_range(2, 0))
				0: tx_gap_max = 0;
				1: tx_gap_max = 11;
				default: tx_gap_max = 3;
			endcase
			case ($urandom_range(2, 0))
				0: rx_stall_max = 0;
				1: rx_stall_max = 11;
				default: rx_stall_max = 3;
			endcase

			len      = ($urandom_range(9, 0) == 0) ? 1 : $urandom_range(40, 2);
			noisy    = ($urandom_range(19, 0) < 3);
			span     = reg_key_max - reg_key_min;
			step_max = span / 64'(len + 1);
			off      = 64'd0;
			for (j = 0; j < len; j++) begin
				room = span - off;
				key  = 64'd0;
				if (noisy) begin
					key = ($urandom_range(1, 0) == 0) ? rand64() : reg_key_min + rand_upto(span);
				end else begin
					case ($urandom_range(19, 0))
						0: ;
						1: off = rand_upto(off);
						2: off = off + rand_upto(room);
						3: key = rand64();
						default: off = off + rand_upto((room < step_max) ? room : step_max);
					endcase
					if (j == len - 1 && $urandom_range(1, 0) == 1)
						off = span;
					if (key == 64'd0)
						key = reg_key_min + off;
				end
				send_key(key, j == len - 1);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_KEY_MIN;
		cfg_wdata        = '0;
		key_ch.valid     = 1'b0;
		key_ch.key       = '0;
		key_ch.last_item = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_bucket();
		test_full_range();
		test_bucket_edges();
		test_random_arrays();

		wait_for_table();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
